[rtl/core/cpu8_alu_with_decimal_mode_macros.svh]
// assertion helpers shared by the checker
`ifndef CPU8_ALU_WITH_DECIMAL_MODE_MACROS_SVH
`define CPU8_ALU_WITH_DECIMAL_MODE_MACROS_SVH

// concurrent check, sampled on the block clock, off while in reset
`define C8_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// check in the cycle after a condition
`define C8_ASSERT_NEXT(lbl, pre, post, msg) \
  `C8_ASSERT(lbl, (pre) |=> (post), msg)

`endif

[rtl/core/c8alu_pkg.sv]
package c8alu_pkg;

  // command codes
  typedef enum logic [3:0] {
    CMD_ADC      = 4'd0,
    CMD_SBC_NMOS = 4'd1,
    CMD_SBC_CMOS = 4'd2,
    CMD_CMP      = 4'd3,
    CMD_BIT      = 4'd4,
    CMD_ASL      = 4'd5,
    CMD_LSR      = 4'd6,
    CMD_ROR      = 4'd7,
    CMD_ROL      = 4'd8,
    CMD_ASR      = 4'd9,
    CMD_ARR      = 4'd10
  } cmd_e;

  // status bit positions
  localparam int unsigned FL_N = 7;
  localparam int unsigned FL_V = 6;
  localparam int unsigned FL_D = 3;
  localparam int unsigned FL_Z = 1;
  localparam int unsigned FL_C = 0;

  // incoming word as it enters the pipe
  typedef struct packed {
    logic [3:0] cmd;
    logic [7:0] a;
    logic [7:0] m;
    logic [7:0] p;
  } op_t;

  // after stage 1: binary sum or difference, low nibble, finished simple ops
  typedef struct packed {
    op_t        op;
    logic [8:0] bin;
    logic [5:0] lo;
    logic [7:0] simple_r;
    logic [7:0] simple_p;
  } s1_t;

  // after stage 2: decimal high nibble
  typedef struct packed {
    s1_t        s1;
    logic [4:0] hi;
  } s2_t;

  // result word
  typedef struct packed {
    logic [7:0] result_byte;
    logic [7:0] status_out;
  } rsp_t;

  // {n, z} of a byte
  function automatic logic [1:0] nz_of(input logic [7:0] v);
    return {v[7], ~|v};
  endfunction

endpackage

[rtl/core/c8alu_if.sv]
// request channel: command and operands
interface c8alu_req_if;
  logic       valid;
  logic       ready;
  logic [3:0] command;
  logic [7:0] acc_in;
  logic [7:0] operand;
  logic [7:0] status_in;

  modport source (output valid, command, acc_in, operand, status_in, input ready);
  modport sink   (input valid, command, acc_in, operand, status_in, output ready);
endinterface

// response channel: new byte and status
interface c8alu_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] result_byte;
  logic [7:0] status_out;

  modport source (output valid, result_byte, status_out, input ready);
  modport sink   (input valid, result_byte, status_out, output ready);
endinterface

[rtl/core/c8alu_lo.sv]
module c8alu_lo import c8alu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  op_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output s1_t  out_data_o
);

  logic       valid_q;
  s1_t        data_q;
  s1_t        data_d;
  logic [7:0] a, m, p;
  logic       cin, dec;
  logic [8:0] add9, sub9, cmp9;
  logic [4:0] lo_sum, lo_sub;
  logic [5:0] lo_add;
  logic [7:0] sr, sp, t;

  // binary arithmetic, low nibble and the single-stage commands
  always_comb begin
    a   = in_data_i.a;
    m   = in_data_i.m;
    p   = in_data_i.p;
    cin = p[FL_C];
    dec = p[FL_D];
    add9   = {1'b0, a} + {1'b0, m} + {8'd0, cin};
    sub9   = {1'b0, a} - {1'b0, m} - {8'd0, ~cin};
    cmp9   = {1'b0, a} - {1'b0, m};
    lo_sum = {1'b0, a[3:0]} + {1'b0, m[3:0]} + {4'd0, cin};
    lo_add = (lo_sum > 5'd9) ? ({1'b0, lo_sum} + 6'd6) : {1'b0, lo_sum};
    lo_sub = {1'b0, a[3:0]} - {1'b0, m[3:0]} - {4'd0, ~cin};
    sr = a;
    sp = p;
    t  = {cin, a[7:1]};
    unique case (in_data_i.cmd)
      CMD_CMP: begin
        {sp[FL_N], sp[FL_Z]} = nz_of(cmp9[7:0]);
        sp[FL_C] = ~cmp9[8];
      end
      CMD_BIT: begin
        sp[FL_Z] = ~|(a & m);
        sp[FL_N] = m[7];
        sp[FL_V] = m[6];
      end
      CMD_ASL: begin
        sr = {m[6:0], 1'b0};
        {sp[FL_N], sp[FL_Z]} = nz_of(sr);
        sp[FL_C] = m[7];
      end
      CMD_LSR: begin
        sr = {1'b0, m[7:1]};
        {sp[FL_N], sp[FL_Z]} = nz_of(sr);
        sp[FL_C] = m[0];
      end
      CMD_ROR: begin
        sr = {cin, m[7:1]};
        {sp[FL_N], sp[FL_Z]} = nz_of(sr);
        sp[FL_C] = m[0];
      end
      CMD_ROL: begin
        sr = {m[6:0], cin};
        {sp[FL_N], sp[FL_Z]} = nz_of(sr);
        sp[FL_C] = m[7];
      end
      CMD_ASR: begin
        sr = {1'b0, m[7:1]};
        sp[FL_C] = m[0];
        sp[FL_Z] = ~|sr;
        sp[FL_N] = (|sr) & sr[6];
        sr[7]    = sp[FL_N];
      end
      CMD_ARR: begin
        {sp[FL_N], sp[FL_Z]} = nz_of(t);
        if (dec) begin
          sp[FL_V] = t[6] ^ a[6];
          if (a[3:0] >= 4'd5) begin
            t[3:0] = t[3:0] + 4'd6;
          end
          sp[FL_C] = (a[7:4] >= 4'd5);
          if (sp[FL_C]) begin
            t = t + 8'h60;
          end
        end else begin
          sp[FL_C] = t[6];
          sp[FL_V] = t[6] ^ t[5];
        end
        sr = t;
      end
      default: begin
      end
    endcase
    data_d.op       = in_data_i;
    data_d.bin      = (in_data_i.cmd == CMD_ADC) ? add9 : sub9;
    data_d.lo       = (in_data_i.cmd == CMD_ADC) ? lo_add : {1'b0, lo_sub};
    data_d.simple_r = sr;
    data_d.simple_p = sp;
  end

  // stage handshake
  assign in_ready_o = ~valid_q | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

[rtl/core/c8alu_hi.sv]
module c8alu_hi import c8alu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  s1_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output s2_t  out_data_o
);

  logic       valid_q;
  s2_t        data_q;
  s2_t        data_d;
  logic [3:0] a_hi, m_hi;
  logic       lo_carry, lo_neg;

  // decimal high nibble, carry or borrow from the low nibble
  always_comb begin
    a_hi     = in_data_i.op.a[7:4];
    m_hi     = in_data_i.op.m[7:4];
    lo_carry = |in_data_i.lo[5:4];
    lo_neg   = in_data_i.lo[4];
    data_d.s1 = in_data_i;
    if (in_data_i.op.cmd == CMD_ADC) begin
      data_d.hi = {1'b0, a_hi} + {1'b0, m_hi} + {4'd0, lo_carry};
    end else begin
      data_d.hi = {1'b0, a_hi} - {1'b0, m_hi} - {4'd0, lo_neg};
    end
  end

  // stage handshake
  assign in_ready_o = ~valid_q | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

[rtl/core/c8alu_fix.sv]
module c8alu_fix import c8alu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  s2_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_data_o
);

  logic       valid_q;
  rsp_t       data_q;
  rsp_t       data_d;
  logic [7:0] a, m, p, bin8, cm, r, st;
  logic [8:0] bin;
  logic [5:0] lo;
  logic [4:0] hi;
  logic [5:0] hi_add;
  logic [3:0] lo_n, hi_n;
  logic       dec, bz, sgn;

  // decimal correction and flag assembly
  always_comb begin
    a    = in_data_i.s1.op.a;
    m    = in_data_i.s1.op.m;
    p    = in_data_i.s1.op.p;
    bin  = in_data_i.s1.bin;
    bin8 = bin[7:0];
    lo   = in_data_i.s1.lo;
    hi   = in_data_i.hi;
    dec  = p[FL_D];
    bz   = ~|bin8;
    hi_add = (hi > 5'd9) ? ({1'b0, hi} + 6'd6) : {1'b0, hi};
    lo_n   = lo[4] ? (lo[3:0] - 4'd6) : lo[3:0];
    hi_n   = hi[4] ? (hi[3:0] - 4'd6) : hi[3:0];
    cm     = {hi[3:0], lo[3:0]} - (lo[4] ? 8'h06 : 8'h00) - (hi[4] ? 8'h60 : 8'h00);
    sgn    = dec ? hi[3] : bin[7];
    r  = in_data_i.s1.simple_r;
    st = in_data_i.s1.simple_p;
    unique case (in_data_i.s1.op.cmd)
      CMD_ADC: begin
        st = p;
        st[FL_Z] = bz;
        st[FL_N] = ~bz & sgn;
        st[FL_V] = ~(a[7] ^ m[7]) & (a[7] ^ sgn);
        st[FL_C] = dec ? (|hi_add[5:4]) : bin[8];
        r = dec ? {hi_add[3:0], lo[3:0]} : bin8;
      end
      CMD_SBC_NMOS, CMD_SBC_CMOS: begin
        st = p;
        st[FL_V] = (a[7] ^ m[7]) & (a[7] ^ bin[7]);
        st[FL_C] = ~bin[8];
        {st[FL_N], st[FL_Z]} = nz_of(bin8);
        r = bin8;
        if (dec) begin
          if (in_data_i.s1.op.cmd == CMD_SBC_NMOS) begin
            r = {hi_n, lo_n};
          end else begin
            r = cm;
            {st[FL_N], st[FL_Z]} = nz_of(cm);
          end
        end
      end
      default: begin
      end
    endcase
    data_d.result_byte = r;
    data_d.status_out  = st;
  end

  // output register handshake
  assign in_ready_o = ~valid_q | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

[rtl/core/cpu8_alu_with_decimal_mode.sv]
// 8-bit ALU of the classic processor family with binary and decimal (BCD) ADC,
// NMOS and CMOS SBC, ARR, CMP, BIT and the shifts, flags as on the NMOS part but
// for CMOS SBC. One word is taken and one result delivered per clock unless the
// output stalls; each word passes the three register stages (low nibble and
// binary add, decimal high nibble, correction and flags), the last of which is
// the output register. Input ready follows output ready through the stages, so
// a stalled output only blocks the input once the pipe is full.
module cpu8_alu_with_decimal_mode import c8alu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  c8alu_req_if.sink   in_i,
  c8alu_rsp_if.source out_o
);

  op_t  op;
  s1_t  s1;
  s2_t  s2;
  rsp_t rsp;
  logic v1, v2, r1, r2;

  // incoming word
  assign op.cmd = in_i.command;
  assign op.a   = in_i.acc_in;
  assign op.m   = in_i.operand;
  assign op.p   = in_i.status_in;

  // stage 1: binary arithmetic, low nibble, simple commands
  c8alu_lo u_lo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_data_i   (op),
    .out_valid_o (v1),
    .out_ready_i (r1),
    .out_data_o  (s1)
  );

  // stage 2: decimal high nibble
  c8alu_hi u_hi (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v1),
    .in_ready_o  (r1),
    .in_data_i   (s1),
    .out_valid_o (v2),
    .out_ready_i (r2),
    .out_data_o  (s2)
  );

  // stage 3: correction, flags, output register
  c8alu_fix u_fix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v2),
    .in_ready_o  (r2),
    .in_data_i   (s2),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (rsp)
  );

  assign out_o.result_byte = rsp.result_byte;
  assign out_o.status_out  = rsp.status_out;

endmodule

[rtl/core/c8alu_chk.sv]
`include "cpu8_alu_with_decimal_mode_macros.svh"

module c8alu_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] result_byte_i,
  input logic [7:0] status_out_i
);

  logic        in_acc, out_acc, stall;
  logic [15:0] rsp_word;
  logic [2:0]  cnt_q, cnt_d;

  // words in flight
  assign in_acc  = in_valid_i & in_ready_i;
  assign out_acc = out_valid_i & out_ready_i;
  assign cnt_d   = cnt_q + {2'd0, in_acc} - {2'd0, out_acc};

  // result waiting on the sink
  assign stall    = out_valid_i & ~out_ready_i;
  assign rsp_word = {result_byte_i, status_out_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // a stalled result stays put
  `C8_ASSERT_NEXT(a_out_hold, stall, out_valid_i, "result dropped while stalled")
  `C8_ASSERT_NEXT(a_out_stable, stall, $stable(rsp_word), "result changed while stalled")

  // three stages hold at most three words, and no result without a word inside
  `C8_ASSERT(a_occupancy, (cnt_q <= 3'd3) && (cnt_q != 3'd0 || !out_valid_i), "bad occupancy")

  // a draining output never blocks the input
  `C8_ASSERT(a_ready_pass, out_ready_i |-> in_ready_i, "input blocked while output drains")

endmodule

bind cpu8_alu_with_decimal_mode c8alu_chk u_c8alu_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .result_byte_i (out_o.result_byte),
  .status_out_i  (out_o.status_out)
);

[sim/cpu8_alu_with_decimal_mode_test.sv]
`timescale 1ns / 1ps

module cpu8_alu_with_decimal_mode_test;
  import c8alu_pkg::*;

  localparam int unsigned RANDOM_WORDS = 1350;
  localparam int unsigned QUIET_TAIL   = 150;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT  = 100000;

  // command codes past the last defined one
  localparam logic [3:0] CMD_SPARE_LO = CMD_ARR + 4'd1;
  localparam logic [3:0] CMD_SPARE_HI = '1;

  logic clk_i;
  logic rst_ni;

  c8alu_req_if req_if ();
  c8alu_rsp_if rsp_if ();

  cpu8_alu_with_decimal_mode dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  op_t  queued_ops[$];
  rsp_t predicted_results[$];
  int unsigned failures;
  int unsigned cycle_count;
  int unsigned send_gap;
  int unsigned recv_stall;
  logic req_fire;

  // status byte with n and z taken from a byte
  function automatic logic [7:0] put_nz(input logic [7:0] st, input logic [7:0] v);
    st[FL_Z] = (v == 8'h00);
    st[FL_N] = v[7];
    return st;
  endfunction

  // new byte and status for one alu word
  function automatic rsp_t alu_predict(input op_t w);
    int unsigned au, mu, cin, bw, lo, hi, sum, diff, t;
    logic loneg, hineg;
    logic [7:0] p, r;
    rsp_t res;
    au  = w.a;
    mu  = w.m;
    p   = w.p;
    r   = w.a;
    cin = w.p[FL_C];
    bw  = cin ? 0 : 1;
    case (w.cmd)
      CMD_ADC: begin
        p[FL_N] = 1'b0; p[FL_V] = 1'b0; p[FL_Z] = 1'b0; p[FL_C] = 1'b0;
        if (w.p[FL_D]) begin
          lo = (au & 15) + (mu & 15) + cin;
          if (lo > 9) lo += 6;
          hi = (au >> 4) + (mu >> 4) + ((lo > 15) ? 1 : 0);
          // nmos quirk: z from the binary sum, n from the raw high nibble
          if (((au + mu + cin) & 32'hff) == 0) p[FL_Z] = 1'b1;
          else if (hi & 8) p[FL_N] = 1'b1;
          if (~(au ^ mu) & (au ^ (hi << 4)) & 32'h80) p[FL_V] = 1'b1;
          if (hi > 9) hi += 6;
          if (hi > 15) p[FL_C] = 1'b1;
          r = 8'(((hi << 4) | (lo & 15)) & 32'hff);
        end else begin
          sum = au + mu + cin;
          if ((sum & 32'hff) == 0) p[FL_Z] = 1'b1;
          else if (sum & 32'h80) p[FL_N] = 1'b1;
          if (~(au ^ mu) & (au ^ sum) & 32'h80) p[FL_V] = 1'b1;
          if (sum & 32'hff00) p[FL_C] = 1'b1;
          r = 8'(sum & 32'hff);
        end
      end
      CMD_SBC_NMOS, CMD_SBC_CMOS: begin
        diff = (au - mu - bw) & 32'hffff;
        p[FL_N] = 1'b0; p[FL_V] = 1'b0; p[FL_Z] = 1'b0; p[FL_C] = 1'b0;
        if ((au ^ mu) & (au ^ diff) & 32'h80) p[FL_V] = 1'b1;
        if (au >= mu + bw) p[FL_C] = 1'b1;
        if (!w.p[FL_D]) begin
          r = 8'(diff & 32'hff);
          p = put_nz(p, r);
        end else begin
          lo    = ((au & 15) - (mu & 15) - bw) & 32'hff;
          loneg = lo[7];
          hi    = ((au >> 4) - (mu >> 4) - loneg) & 32'hff;
          hineg = hi[7];
          if (w.cmd == CMD_SBC_NMOS) begin
            // flags of the binary difference, digits fixed separately
            if ((diff & 32'hff) == 0) p[FL_Z] = 1'b1;
            else if (diff & 32'h80) p[FL_N] = 1'b1;
            if (loneg) lo = (lo - 6) & 32'hff;
            if (hineg) hi = (hi - 6) & 32'hff;
            r = 8'(((hi << 4) | (lo & 15)) & 32'hff);
          end else begin
            // cmos fixes the whole byte and flags the corrected value
            r = 8'(((hi << 4) | (lo & 15)) & 32'hff);
            if (loneg) r = r - 8'h06;
            if (hineg) r = r - 8'h60;
            p = put_nz(p, r);
          end
        end
      end
      CMD_CMP: begin
        p[FL_C] = (w.a >= w.m);
        p = put_nz(p, w.a - w.m);
      end
      CMD_BIT: begin
        p[FL_Z] = ((w.a & w.m) == 8'h00);
        p[FL_N] = w.m[7];
        p[FL_V] = w.m[6];
      end
      CMD_ASL: begin
        r = {w.m[6:0], 1'b0};
        p = put_nz(p, r);
        p[FL_C] = w.m[7];
      end
      CMD_LSR: begin
        r = {1'b0, w.m[7:1]};
        p = put_nz(p, r);
        p[FL_C] = w.m[0];
      end
      CMD_ROR: begin
        r = {w.p[FL_C], w.m[7:1]};
        p = put_nz(p, r);
        p[FL_C] = w.m[0];
      end
      CMD_ROL: begin
        r = {w.m[6:0], w.p[FL_C]};
        p = put_nz(p, r);
        p[FL_C] = w.m[7];
      end
      CMD_ASR: begin
        // nonzero result with bit 6 set gets bit 7 and n
        r = {1'b0, w.m[7:1]};
        p[FL_N] = 1'b0;
        p[FL_Z] = (r == 8'h00);
        p[FL_C] = w.m[0];
        if (r != 8'h00 && r[6]) begin
          r[7]    = 1'b1;
          p[FL_N] = 1'b1;
        end
      end
      CMD_ARR: begin
        t = {w.p[FL_C], w.a[7:1]};
        p[FL_V] = 1'b0;
        p[FL_C] = 1'b0;
        p = put_nz(p, 8'(t));
        if (w.p[FL_D]) begin
          if ((t ^ au) & 32'h40) p[FL_V] = 1'b1;
          if ((au & 32'h0f) >= 32'h05) t = ((t + 6) & 32'h0f) | (t & 32'hf0);
          if ((au & 32'hf0) >= 32'h50) begin
            t = (t + 32'h60) & 32'hff;
            p[FL_C] = 1'b1;
          end
        end else begin
          if (t & 32'h40) begin
            p[FL_V] = 1'b1;
            p[FL_C] = 1'b1;
          end
          if (t & 32'h20) p[FL_V] = ~p[FL_V];
        end
        r = 8'(t);
      end
      default: ;
    endcase
    res.result_byte = r;
    res.status_out  = p;
    return res;
  endfunction

  task automatic queue_op(input logic [3:0] cmd, input logic [7:0] a,
                          input logic [7:0] m, input logic [7:0] p);
    op_t w;
    w.cmd = cmd;
    w.a   = a;
    w.m   = m;
    w.p   = p;
    queued_ops.push_back(w);
  endtask

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // request driver, word changes on the falling edge
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || req_fire) begin
      if (send_gap > 0) begin
        req_if.valid <= 1'b0;
        send_gap--;
      end else if (queued_ops.size() == 0) begin
        req_if.valid <= 1'b0;
      end else if (queued_ops.size() > QUIET_TAIL && $urandom_range(7, 0) == 0) begin
        req_if.valid <= 1'b0;
        send_gap = $urandom_range(2, 0);
      end else begin
        op_t w;
        w = queued_ops.pop_front();
        req_if.command   <= w.cmd;
        req_if.acc_in    <= w.a;
        req_if.operand   <= w.m;
        req_if.status_in <= w.p;
        req_if.valid     <= 1'b1;
      end
    end
  end

  // response ready with random stall bursts
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else if (recv_stall > 0) begin
      rsp_if.ready <= 1'b0;
      recv_stall--;
    end else if (queued_ops.size() > QUIET_TAIL && $urandom_range(7, 0) == 0) begin
      rsp_if.ready <= 1'b0;
      recv_stall = $urandom_range(2, 0);
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  // monitor: predict on accepted requests, check accepted responses
  always @(posedge clk_i) begin
    rsp_t got, want;
    op_t  w;
    req_fire <= rst_ni && req_if.valid && req_if.ready;
    if (rst_ni && req_if.valid && req_if.ready) begin
      w.cmd = req_if.command;
      w.a   = req_if.acc_in;
      w.m   = req_if.operand;
      w.p   = req_if.status_in;
      predicted_results.push_back(alu_predict(w));
    end
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got.result_byte = rsp_if.result_byte;
      got.status_out  = rsp_if.status_out;
      if (predicted_results.size() == 0) begin
        $error("unexpected word: result_byte %h status_out %h",
               got.result_byte, got.status_out);
        failures++;
      end else begin
        want = predicted_results.pop_front();
        if (got.result_byte !== want.result_byte) begin
          $error("result_byte: expected %h, got %h", want.result_byte, got.result_byte);
          failures++;
        end
        if (got.status_out !== want.status_out) begin
          $error("status_out: expected %h, got %h", want.status_out, got.status_out);
          failures++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[cpu8_alu_with_decimal_mode] ERROR");
      $finish;
    end
  end

  initial begin
    op_t w;
    req_if.valid     = 1'b0;
    req_if.command   = CMD_ADC;
    req_if.acc_in    = 8'h00;
    req_if.operand   = 8'h00;
    req_if.status_in = 8'h00;
    rsp_if.ready     = 1'b0;
    req_fire         = 1'b0;
    failures         = 0;
    cycle_count      = 0;
    send_gap         = 0;
    recv_stall       = 0;
    rst_ni           = 1'b0;

    // directed words: extremes, every command, decimal quirks
    queue_op(CMD_ADC,      8'h00, 8'h00, 8'h00);
    queue_op(CMD_ADC,      8'hff, 8'hff, 8'hff);
    queue_op(CMD_ADC,      8'h7f, 8'h01, 8'h00);
    queue_op(CMD_ADC,      8'h80, 8'h80, 8'h00);
    queue_op(CMD_ADC,      8'h99, 8'h01, 8'h08);
    queue_op(CMD_ADC,      8'h58, 8'h46, 8'h09);
    queue_op(CMD_ADC,      8'hff, 8'hff, 8'h08);
    queue_op(CMD_SBC_NMOS, 8'h00, 8'h01, 8'h09);
    queue_op(CMD_SBC_NMOS, 8'h80, 8'h01, 8'h01);
    queue_op(CMD_SBC_CMOS, 8'h00, 8'h01, 8'h09);
    queue_op(CMD_SBC_CMOS, 8'h00, 8'h00, 8'h08);
    queue_op(CMD_SBC_CMOS, 8'hff, 8'hff, 8'hf6);
    queue_op(CMD_CMP,      8'h42, 8'h42, 8'h00);
    queue_op(CMD_CMP,      8'h00, 8'hff, 8'hff);
    queue_op(CMD_BIT,      8'h00, 8'hc0, 8'h00);
    queue_op(CMD_ASL,      8'h00, 8'h80, 8'h00);
    queue_op(CMD_LSR,      8'h00, 8'h01, 8'hff);
    queue_op(CMD_ROR,      8'h00, 8'h00, 8'h01);
    queue_op(CMD_ROL,      8'h00, 8'hff, 8'h00);
    queue_op(CMD_ASR,      8'h00, 8'h80, 8'h00);
    queue_op(CMD_ASR,      8'h00, 8'h01, 8'h00);
    queue_op(CMD_ARR,      8'h6a, 8'h00, 8'h00);
    queue_op(CMD_ARR,      8'hff, 8'h00, 8'h09);
    queue_op(CMD_SPARE_LO, 8'h12, 8'h34, 8'h56);
    queue_op(CMD_SPARE_HI, 8'hff, 8'hff, 8'hff);

    // random words, mostly defined commands, often with valid bcd digits
    repeat (RANDOM_WORDS) begin
      w.cmd = 4'($urandom_range(15, 0));
      if (w.cmd > CMD_ARR && $urandom_range(3, 0) != 0)
        w.cmd = 4'($urandom_range(CMD_ARR, CMD_ADC));
      if ($urandom_range(1, 0) == 0) begin
        w.a = {4'($urandom_range(9, 0)), 4'($urandom_range(9, 0))};
        w.m = {4'($urandom_range(9, 0)), 4'($urandom_range(9, 0))};
      end else begin
        w.a = 8'($urandom_range(255, 0));
        w.m = 8'($urandom_range(255, 0));
      end
      w.p = 8'($urandom_range(255, 0));
      queued_ops.push_back(w);
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // every word accepted, then every result back
    do @(posedge clk_i); while (queued_ops.size() != 0 || req_if.valid);
    @(negedge clk_i);
    while (predicted_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (predicted_results.size() != 0) begin
      $error("%0d expected words never arrived", predicted_results.size());
      failures++;
    end

    if (failures == 0) begin
      $display("[cpu8_alu_with_decimal_mode] OK");
    end else begin
      $display("[cpu8_alu_with_decimal_mode] ERROR");
    end
    $finish;
  end

endmodule
